### hw/rtl/sbfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfr_pkg
// shared types and constants of the frame receiver
// ----------------------------------------------------------------------------
package sbfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int RAW_W        = 11;
    localparam int VALUE_W      = 12;
    localparam int CHAN_BYTES   = 22;
    localparam int FLAG_POS     = 22;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 4;
    localparam int FILL_W       = 5;
    localparam int ADDR_W       = $clog2(CHAN_BYTES);
    localparam int ACC_W        = RAW_W + BYTE_W;
    localparam int CNT_W        = $clog2(ACC_W + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;

    localparam logic [BYTE_W-1:0] HEADER_RST   = 8'd15;
    localparam logic [BYTE_W-1:0] FOOTER_RST   = 8'd0;
    localparam logic [RAW_W-1:0]  OFFSET_RST   = 11'd172;
    localparam logic [BYTE_W-1:0] DIG_ONE_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] DIG_TWO_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] LOST_RST     = 8'd4;
    localparam logic [BYTE_W-1:0] FAILSAFE_RST = 8'd8;

    typedef logic [ADDR_W-1:0] store_addr_t;

    typedef struct packed {
        logic              en;
        store_addr_t       addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER   = 3'd0,
        CFG_FOOTER   = 3'd1,
        CFG_OFFSET   = 3'd2,
        CFG_DIG_ONE  = 3'd3,
        CFG_DIG_TWO  = 3'd4,
        CFG_LOST     = 3'd5,
        CFG_FAILSAFE = 3'd6
    } cfg_idx_t;

endpackage

### hw/rtl/sbus_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// serial frame decoder giving sixteen 11-bit channels and four flags a frame
// ----------------------------------------------------------------------------
// usage
//   input channel: one received byte per item on rx_byte, in_valid / in_stall
//   output channel: one item per channel, channel_index 0..15, last_channel
//     marks the sixteenth, out_valid / out_stall
//   configuration: cfg_we with cfg_index and cfg_data, written while idle
// timing
//   a byte that does not complete a frame is taken while idle, back to back
//   the byte that completes a frame starts the unpacker: it reads the 22
//   packed bytes from the frame store one at a time (memory read, then
//   merge into a bit accumulator) and sends a channel through a shared
//   subtractor whenever 11 bits are held
//   the first channel item appears once the merges hold 11 bits
//   in_stall is high for the whole unpack, including any output stall
// reset
//   fill count cleared, previous byte taken as the footer reset value,
//   registers take their reset values, no output item pending
// stalls
//   a single output register holds the pending item; the unpacker waits
//   while it is full and stalled, and no byte is taken during that wait
// ----------------------------------------------------------------------------
module sbus_frame_receiver #(
    parameter int FRAME_BYTES = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 cfg_we,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sbfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // byte input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sbfr_pkg::BYTE_W-1:0]          rx_byte,
    // channel output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sbfr_pkg::CHAN_W-1:0]          channel_index,
    output logic signed [sbfr_pkg::VALUE_W-1:0]  channel_value,
    output logic                                 digital_one,
    output logic                                 digital_two,
    output logic                                 failsafe_flag,
    output logic                                 lost_flag,
    output logic                                 last_channel
);

    typedef enum logic [1:0] {
        IDLE,
        FETCH,
        MERGE,
        EMIT
    } state_t;

    // configuration registers
    logic [sbfr_pkg::BYTE_W-1:0]  header_reg;
    logic [sbfr_pkg::BYTE_W-1:0]  footer_reg;
    logic [sbfr_pkg::RAW_W-1:0]   offset_reg;
    logic [sbfr_pkg::BYTE_W-1:0]  dig_one_mask_reg;
    logic [sbfr_pkg::BYTE_W-1:0]  dig_two_mask_reg;
    logic [sbfr_pkg::BYTE_W-1:0]  lost_mask_reg;
    logic [sbfr_pkg::BYTE_W-1:0]  failsafe_mask_reg;

    // frame fill and unpack state
    state_t                       state_reg;
    logic [sbfr_pkg::FILL_W-1:0]  fill_reg;
    logic [sbfr_pkg::BYTE_W-1:0]  prev_reg;
    logic [sbfr_pkg::BYTE_W-1:0]  flags_reg;
    sbfr_pkg::store_addr_t        rd_addr_reg;
    logic [sbfr_pkg::ACC_W-1:0]   acc_reg;
    logic [sbfr_pkg::CNT_W-1:0]   cnt_reg;
    logic [sbfr_pkg::CHAN_W-1:0]  chan_reg;

    // output register
    logic                                 out_valid_reg;
    logic [sbfr_pkg::CHAN_W-1:0]          chan_out_reg;
    logic [sbfr_pkg::VALUE_W-1:0]         value_out_reg;
    logic                                 dig_one_out_reg;
    logic                                 dig_two_out_reg;
    logic                                 failsafe_out_reg;
    logic                                 lost_out_reg;
    logic                                 last_out_reg;

    logic                         restart;
    logic [sbfr_pkg::FILL_W-1:0]  fill_next;
    logic                         frame_done;
    logic [sbfr_pkg::BYTE_W-1:0]  rd_data;
    logic [sbfr_pkg::CNT_W-1:0]   merge_cnt;
    logic [sbfr_pkg::CNT_W-1:0]   emit_cnt;
    logic                         emit_go;
    logic [sbfr_pkg::VALUE_W-1:0] value_next;
    sbfr_pkg::store_wr_t          store_wr;

    // header straight after a footer restarts the fill
    assign restart    = (rx_byte == header_reg) && (prev_reg == footer_reg);
    assign fill_next  = fill_reg + sbfr_pkg::FILL_W'(1);
    assign frame_done = !restart && (fill_next == sbfr_pkg::FILL_W'(FRAME_BYTES));

    assign merge_cnt  = cnt_reg + sbfr_pkg::CNT_W'(sbfr_pkg::BYTE_W);
    assign emit_cnt   = cnt_reg - sbfr_pkg::CNT_W'(sbfr_pkg::RAW_W);
    assign emit_go    = (state_reg == EMIT) && (!out_valid_reg || !out_stall);

    // shared subtractor, wraps to 12-bit two's complement
    assign value_next = {1'b0, acc_reg[sbfr_pkg::RAW_W-1:0]} - {1'b0, offset_reg};

    // only the packed channel bytes go to the store, the flag byte is kept apart
    always_comb
    begin
        store_wr.en   = (state_reg == IDLE) && in_valid && !restart
                        && (fill_reg < sbfr_pkg::FILL_W'(sbfr_pkg::CHAN_BYTES));
        store_wr.addr = sbfr_pkg::ADDR_W'(fill_reg);
        store_wr.data = rx_byte;
    end

    sbfr_frame_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg        <= sbfr_pkg::HEADER_RST;
            footer_reg        <= sbfr_pkg::FOOTER_RST;
            offset_reg        <= sbfr_pkg::OFFSET_RST;
            dig_one_mask_reg  <= sbfr_pkg::DIG_ONE_RST;
            dig_two_mask_reg  <= sbfr_pkg::DIG_TWO_RST;
            lost_mask_reg     <= sbfr_pkg::LOST_RST;
            failsafe_mask_reg <= sbfr_pkg::FAILSAFE_RST;
        end
        else if (cfg_we)
        begin
            unique case (sbfr_pkg::cfg_idx_t'(cfg_index))
                sbfr_pkg::CFG_HEADER:   header_reg        <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                sbfr_pkg::CFG_FOOTER:   footer_reg        <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                sbfr_pkg::CFG_OFFSET:   offset_reg        <= cfg_data[sbfr_pkg::RAW_W-1:0];
                sbfr_pkg::CFG_DIG_ONE:  dig_one_mask_reg  <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                sbfr_pkg::CFG_DIG_TWO:  dig_two_mask_reg  <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                sbfr_pkg::CFG_LOST:     lost_mask_reg     <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                sbfr_pkg::CFG_FAILSAFE: failsafe_mask_reg <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            fill_reg         <= '0;
            prev_reg         <= sbfr_pkg::FOOTER_RST;
            flags_reg        <= '0;
            rd_addr_reg      <= '0;
            acc_reg          <= '0;
            cnt_reg          <= '0;
            chan_reg         <= '0;
            out_valid_reg    <= 1'b0;
            chan_out_reg     <= '0;
            value_out_reg    <= '0;
            dig_one_out_reg  <= 1'b0;
            dig_two_out_reg  <= 1'b0;
            failsafe_out_reg <= 1'b0;
            lost_out_reg     <= 1'b0;
            last_out_reg     <= 1'b0;
        end
        else
        begin
            // output register: loaded by the unpacker, emptied when taken
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        if (frame_done)
                        begin
                            fill_reg    <= '0;
                            prev_reg    <= footer_reg;
                            rd_addr_reg <= '0;
                            acc_reg     <= '0;
                            cnt_reg     <= '0;
                            chan_reg    <= '0;
                            state_reg   <= FETCH;
                        end
                        else
                        begin
                            prev_reg <= rx_byte;
                            fill_reg <= restart ? '0 : fill_next;
                        end
                        if (!restart && (fill_reg == sbfr_pkg::FILL_W'(sbfr_pkg::FLAG_POS)))
                        begin
                            flags_reg <= rx_byte;
                        end
                    end
                end

                FETCH:
                begin
                    // store read in flight
                    state_reg <= MERGE;
                end

                MERGE:
                begin
                    acc_reg     <= acc_reg | (sbfr_pkg::ACC_W'(rd_data) << cnt_reg);
                    cnt_reg     <= merge_cnt;
                    rd_addr_reg <= rd_addr_reg + sbfr_pkg::ADDR_W'(1);
                    state_reg   <= (merge_cnt >= sbfr_pkg::CNT_W'(sbfr_pkg::RAW_W))
                                   ? EMIT : FETCH;
                end

                EMIT:
                begin
                    if (emit_go)
                    begin
                        chan_out_reg     <= chan_reg;
                        value_out_reg    <= value_next;
                        dig_one_out_reg  <= |(flags_reg & dig_one_mask_reg);
                        dig_two_out_reg  <= |(flags_reg & dig_two_mask_reg);
                        failsafe_out_reg <= |(flags_reg & failsafe_mask_reg);
                        lost_out_reg     <= |(flags_reg & lost_mask_reg);
                        last_out_reg     <= &chan_reg;
                        acc_reg          <= acc_reg >> sbfr_pkg::RAW_W;
                        cnt_reg          <= emit_cnt;
                        chan_reg         <= chan_reg + sbfr_pkg::CHAN_W'(1);
                        if (&chan_reg)
                        begin
                            state_reg <= IDLE;
                        end
                        else if (emit_cnt >= sbfr_pkg::CNT_W'(sbfr_pkg::RAW_W))
                        begin
                            state_reg <= EMIT;
                        end
                        else
                        begin
                            state_reg <= FETCH;
                        end
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != IDLE);
    assign out_valid     = out_valid_reg;
    assign channel_index = chan_out_reg;
    assign channel_value = signed'(value_out_reg);
    assign digital_one   = dig_one_out_reg;
    assign digital_two   = dig_two_out_reg;
    assign failsafe_flag = failsafe_out_reg;
    assign lost_flag     = lost_out_reg;
    assign last_channel  = last_out_reg;

`ifndef SYNTHESIS
    // last marker sits on channel fifteen only
    a_last_on_fifteen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_channel == (channel_index == sbfr_pkg::CHAN_W'(15))))
        else $error("last_channel out of step with channel_index");

    // all 176 packed bits are used up by the sixteenth channel
    a_bits_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && (&chan_reg)) |-> (cnt_reg == sbfr_pkg::CNT_W'(sbfr_pkg::RAW_W)))
        else $error("bit accumulator not drained at end of frame");

    // fill never reaches the frame length while taking bytes
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE) |-> (fill_reg < sbfr_pkg::FILL_W'(FRAME_BYTES)))
        else $error("fill count reached frame length while idle");

    // unpacker reads only packed channel bytes
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FETCH) |-> (rd_addr_reg < sbfr_pkg::ADDR_W'(sbfr_pkg::CHAN_BYTES)))
        else $error("frame store read beyond channel bytes");
`endif

endmodule

### hw/rtl/sbfr_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfr_frame_store
// byte memory holding the packed channel bytes of one frame
// ----------------------------------------------------------------------------
module sbfr_frame_store (
    input  logic                          clk,
    input  sbfr_pkg::store_wr_t           wr,
    input  sbfr_pkg::store_addr_t         rd_addr,
    output logic [sbfr_pkg::BYTE_W-1:0]   rd_data
);

    logic [sbfr_pkg::BYTE_W-1:0] mem [sbfr_pkg::CHAN_BYTES];
    logic [sbfr_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
